// ===== sv/abfd_pkg.sv =====
// Shared constants, types and tables of the box-filter decimator.
package abfd_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int IN_WORDS     = 4;
	localparam int FRAC_BITS    = 16;
	localparam int WORD_W       = 32;
	localparam int LEVEL_W      = 8;
	localparam int OUT_W        = 8;
	localparam int SB_W         = 3;
	localparam int NCH_W        = $clog2(MAX_CHANNELS + 1);
	localparam int STEP_W       = 24;
	localparam int INV_W        = FRAC_BITS + 1;
	localparam int RECIP_W      = FRAC_BITS + 1;
	localparam int SUM_W        = LEVEL_W + $clog2(MAX_CHANNELS + 1);
	localparam int AVG_W        = SUM_W + RECIP_W + 1;
	localparam int PROD_W       = AVG_W + FRAC_BITS + 1;
	localparam int ACC_W        = 34;
	localparam int ACC_LO_W     = ACC_W / 2;
	localparam int ACC_HI_W     = ACC_W - ACC_LO_W;
	localparam int PLO_W        = ACC_LO_W + INV_W;
	localparam int FULL_W       = ACC_W + INV_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = STEP_W;
	localparam int IN_DATA_W    = IN_WORDS * WORD_W;

	localparam logic [STEP_W-1:0] ONE_Q = STEP_W'(1) << FRAC_BITS;

	localparam logic [SB_W-1:0] SB_U8  = 3'd1;
	localparam logic [SB_W-1:0] SB_S16 = 3'd2;
	localparam logic [SB_W-1:0] SB_S24 = 3'd3;
	localparam logic [SB_W-1:0] SB_S32 = 3'd4;

	typedef logic signed [LEVEL_W-1:0] level_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_BYTES,
		CFG_NUM_CHANNELS,
		CFG_STEP,
		CFG_INV_STEP
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_AVG,
		ST_WIN,
		ST_PART
	} ctrl_state_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_LO,
		EM_HI,
		EM_FIN
	} em_state_t;

	typedef struct packed {
		logic                    valid;
		logic signed [ACC_W-1:0] acc;
	} emit_req_t;

	function automatic logic [RECIP_W-1:0] recip_of(input int unsigned n);
		logic [RECIP_W-1:0] r;
		unique case (n)
			1:       r = RECIP_W'((ONE_Q + 0) / 1);
			2:       r = RECIP_W'((ONE_Q + 1) / 2);
			3:       r = RECIP_W'((ONE_Q + 1) / 3);
			4:       r = RECIP_W'((ONE_Q + 2) / 4);
			5:       r = RECIP_W'((ONE_Q + 2) / 5);
			6:       r = RECIP_W'((ONE_Q + 3) / 6);
			7:       r = RECIP_W'((ONE_Q + 3) / 7);
			8:       r = RECIP_W'((ONE_Q + 4) / 8);
			default: r = RECIP_W'(ONE_Q);
		endcase
		return r;
	endfunction

endpackage

// ===== sv/abfd_lane.sv =====
// One channel lane: raw sample word to signed 8-bit level.
module abfd_lane import abfd_pkg::*; (
	input  logic              clk,
	input  logic              load,
	input  logic [WORD_W-1:0] word,
	input  logic [SB_W-1:0]   sample_bytes,
	input  logic              enable,
	output level_t            level_q
);

	level_t level;

	always_comb begin
		unique case (sample_bytes)
			SB_U8:   level = $signed({~word[7], word[6:0]});
			SB_S16:  level = $signed(word[15:8]);
			SB_S24:  level = $signed(word[23:16]);
			SB_S32:  level = $signed(word[31:24]);
			default: level = '0;
		endcase
		if (!enable) begin
			level = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			level_q <= level;
		end
	end

endmodule

// ===== sv/abfd_merge.sv =====
// Lane merge: sum of channel levels scaled by the channel-count reciprocal.
module abfd_merge import abfd_pkg::*; (
	input  logic                    clk,
	input  logic                    load,
	input  level_t                  levels [MAX_CHANNELS],
	input  logic [NCH_W-1:0]        n_eff,
	output logic signed [AVG_W-1:0] avg_q
);

	logic signed [SUM_W-1:0]   sum;
	logic [RECIP_W-1:0]        recip;
	logic signed [AVG_W-1:0]   avg;

	always_comb begin
		sum = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			sum = sum + SUM_W'(levels[i]);
		end
		recip = recip_of(int'(n_eff));
		avg   = AVG_W'(sum) * AVG_W'($signed({1'b0, recip}));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			avg_q <= avg;
		end
	end

endmodule

// ===== sv/abfd_emit.sv =====
// Output unit: window sum times reciprocal step, rounded, saturated, registered.
module abfd_emit import abfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  emit_req_t        req,
	input  logic [INV_W-1:0] inv_step,
	output logic             ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int HPROD_W = ACC_HI_W + INV_W + 1;
	localparam logic signed [FULL_W-1:0] OUT_MAX = FULL_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic signed [FULL_W-1:0] OUT_MIN = -FULL_W'(2 ** (OUT_W - 1));

	em_state_t                          em_state_q, em_state_d;
	logic signed [ACC_W-1:0]            acc_q;
	logic [PLO_W-1:0]                   plo_q;
	logic signed [FULL_W-1:0]           full_q;
	logic signed [HPROD_W-1:0]          hi_prod;
	logic signed [FULL_W-1:0]           full_d;
	logic signed [FULL_W-1:0]           half_m;
	logic signed [FULL_W-1:0]           rnd;
	logic signed [FULL_W-1:0]           y;
	logic [OUT_W-1:0]                   sat;
	logic                               out_free;
	logic                               out_load;

	always_comb begin
		hi_prod = HPROD_W'($signed(acc_q[ACC_W-1:ACC_LO_W]))
			* HPROD_W'($signed({1'b0, inv_step}));
		full_d  = (FULL_W'(hi_prod) <<< ACC_LO_W)
			+ $signed({{(FULL_W - PLO_W){1'b0}}, plo_q});
		half_m  = (FULL_W'(1) << (2 * FRAC_BITS - 1)) - FULL_W'(full_q[FULL_W-1]);
		rnd     = full_q + half_m;
		y       = rnd >>> (2 * FRAC_BITS);
		priority if (y > OUT_MAX) begin
			sat = OUT_MAX[OUT_W-1:0];
		end else if (y < OUT_MIN) begin
			sat = OUT_MIN[OUT_W-1:0];
		end else begin
			sat = y[OUT_W-1:0];
		end
	end

	always_comb begin
		em_state_d = em_state_q;
		ready      = 1'b0;
		out_free   = !m_tvalid || m_tready;
		out_load   = 1'b0;
		unique case (em_state_q)
			EM_IDLE: begin
				ready = 1'b1;
				if (req.valid) begin
					em_state_d = EM_LO;
				end
			end
			EM_LO: em_state_d = EM_HI;
			EM_HI: em_state_d = EM_FIN;
			EM_FIN: begin
				if (out_free) begin
					out_load   = 1'b1;
					em_state_d = EM_IDLE;
				end
			end
			default: em_state_d = EM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_state_q <= EM_IDLE;
			m_tvalid   <= 1'b0;
		end else begin
			em_state_q <= em_state_d;
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready && req.valid) begin
			acc_q <= req.acc;
		end
		if (em_state_q == EM_LO) begin
			plo_q <= PLO_W'(acc_q[ACC_LO_W-1:0]) * PLO_W'(inv_step);
		end
		if (em_state_q == EM_HI) begin
			full_q <= full_d;
		end
		if (out_load) begin
			m_tdata <= sat;
		end
	end

`ifndef SYNTHESIS
	a_start_to_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(ready && req.valid) |=> em_state_q == EM_LO)
		else $error("emit unit did not start multiply");
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(em_state_q == EM_FIN && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("finished sample not presented");
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(em_state_q == EM_FIN && m_tvalid && !m_tready) |=> em_state_q == EM_FIN)
		else $error("finished sample dropped while output full");
`endif

endmodule

// ===== sv/audio_box_filter_downsampler_core.sv =====
// Top level of the box-filter decimator: config, lanes, window sequencer, output unit.
//
// Each input transaction carries one PCM frame of up to four channel words. Four
// lanes convert the words to signed 8-bit levels in parallel, a merge stage forms
// the Q8.16 frame average, and a window sequencer integrates averages over windows
// of step_q16 frames, splitting a straddling frame by weight. A frame passes through
// accept, average and window update, plus a weighting multiply when it straddles a
// window boundary; the next frame is accepted only once the window update is done.
// A closed window is scaled by inv_step_q16 in a separate unit that overlaps the
// next frames and feeds an output register, so the input side stalls only when a
// second window closes before that unit is free. Writing step_q16 restarts the
// current window. There is no clearing pass after reset.
module audio_box_filter_downsampler_core import abfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// chan0_word, chan1_word, chan2_word, chan3_word
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_sample
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SB_W-1:0]             sample_bytes_q;
	logic [NCH_W-1:0]            num_channels_q;
	logic [STEP_W-1:0]           step_q;
	logic [INV_W-1:0]            inv_step_q;

	ctrl_state_t                 state_q, state_d;
	logic [STEP_W-1:0]           wr_q, wr_d;
	logic signed [ACC_W-1:0]     acc_q, acc_d;
	logic signed [PROD_W-1:0]    part_prod_q;

	logic [NCH_W-1:0]            n_eff;
	level_t                      levels [MAX_CHANNELS];
	logic signed [AVG_W-1:0]     avg_q;
	logic                        accept;
	logic                        prod_load;
	logic [STEP_W-1:0]           eff_step;
	logic [STEP_W-1:0]           cfg_eff_step;
	logic [STEP_W-1:0]           wr_cur;
	logic [STEP_W-1:0]           wr_dec;
	logic signed [ACC_W-1:0]     avg_ext;
	logic signed [ACC_W-1:0]     acc_sum;
	logic signed [PROD_W-1:0]    prod;
	logic signed [PROD_W-1:0]    half_m;
	logic signed [PROD_W-1:0]    part_rnd;
	logic signed [ACC_W-1:0]     part_acc;
	emit_req_t                   emit_req;
	logic                        em_ready;

	always_comb begin
		if (num_channels_q == '0) begin
			n_eff = NCH_W'(1);
		end else if (num_channels_q > NCH_W'(MAX_CHANNELS)) begin
			n_eff = NCH_W'(MAX_CHANNELS);
		end else begin
			n_eff = num_channels_q;
		end
	end

	assign accept = s_tvalid && s_tready;

	for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
		if (i < IN_WORDS) begin : g_word
			abfd_lane u_lane (
				.clk          (clk),
				.load         (accept),
				.word         (s_tdata[i*WORD_W +: WORD_W]),
				.sample_bytes (sample_bytes_q),
				.enable       (NCH_W'(i) < n_eff),
				.level_q      (levels[i])
			);
		end else begin : g_none
			abfd_lane u_lane (
				.clk          (clk),
				.load         (accept),
				.word         ('0),
				.sample_bytes (sample_bytes_q),
				.enable       (1'b0),
				.level_q      (levels[i])
			);
		end
	end

	abfd_merge u_merge (
		.clk    (clk),
		.load   (state_q == ST_AVG),
		.levels (levels),
		.n_eff  (n_eff),
		.avg_q  (avg_q)
	);

	always_comb begin
		eff_step     = (step_q < ONE_Q) ? ONE_Q : step_q;
		cfg_eff_step = (cfg_data[STEP_W-1:0] < ONE_Q) ? ONE_Q : cfg_data[STEP_W-1:0];
		wr_cur       = (wr_q == '0) ? eff_step : wr_q;
		wr_dec       = wr_cur - ONE_Q;
		avg_ext      = ACC_W'(avg_q);
		acc_sum      = acc_q + avg_ext;
		prod         = PROD_W'(avg_q) * PROD_W'($signed({1'b0, wr_cur[FRAC_BITS-1:0]}));
		half_m       = (PROD_W'(1) << (FRAC_BITS - 1)) - PROD_W'(part_prod_q[PROD_W-1]);
		part_rnd     = part_prod_q + half_m;
		part_acc     = ACC_W'(part_rnd >>> FRAC_BITS);
	end

	always_comb begin
		state_d      = state_q;
		wr_d         = wr_q;
		acc_d        = acc_q;
		prod_load    = 1'b0;
		s_tready     = 1'b0;
		emit_req     = '{valid: 1'b0, acc: acc_sum};
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: state_d = ST_WIN;
			ST_WIN: begin
				if (wr_cur >= ONE_Q) begin
					if (wr_dec == '0) begin
						emit_req.valid = 1'b1;
						if (em_ready) begin
							acc_d   = '0;
							wr_d    = eff_step;
							state_d = ST_IDLE;
						end
					end else begin
						acc_d   = acc_sum;
						wr_d    = wr_dec;
						state_d = ST_IDLE;
					end
				end else begin
					prod_load = 1'b1;
					wr_d      = wr_cur;
					state_d   = ST_PART;
				end
			end
			ST_PART: begin
				emit_req.valid = 1'b1;
				emit_req.acc   = acc_q + part_acc;
				if (em_ready) begin
					acc_d   = avg_ext - part_acc;
					wr_d    = eff_step - ONE_Q + wr_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bytes_q <= SB_S16;
			num_channels_q <= NCH_W'(1);
			step_q         <= ONE_Q;
			inv_step_q     <= INV_W'(ONE_Q);
			state_q        <= ST_IDLE;
			wr_q           <= ONE_Q;
			acc_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_idx_t'(cfg_index) == CFG_STEP) begin
				wr_q  <= cfg_eff_step;
				acc_q <= '0;
			end else begin
				wr_q  <= wr_d;
				acc_q <= acc_d;
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SAMPLE_BYTES: sample_bytes_q <= cfg_data[SB_W-1:0];
					CFG_NUM_CHANNELS: num_channels_q <= cfg_data[NCH_W-1:0];
					CFG_STEP:         step_q <= cfg_data[STEP_W-1:0];
					CFG_INV_STEP:     inv_step_q <= cfg_data[INV_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_load) begin
			part_prod_q <= prod;
		end
	end

	abfd_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (emit_req),
		.inv_step (inv_step_q),
		.ready    (em_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	a_accept_to_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == ST_AVG)
		else $error("accepted frame did not enter averaging");
	a_part_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PART && em_ready) |=> state_q == ST_IDLE)
		else $error("straddling frame not retired after emit handoff");
	a_step_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == CFG_STEP) |=> acc_q == '0)
		else $error("step write did not restart window");
`endif

endmodule

// ===== verif/audio_box_filter_downsampler_core_tb.sv =====
// Self-checking testbench for the box-filter decimator with a fixed-point window predictor.
module audio_box_filter_downsampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import abfd_pkg::*;

	localparam int U8_OFFSET      = 'h80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PRESSURE_HOLD  = 300;

	class decim_scoreboard;
		logic [SB_W-1:0]    bytes_sel;
		logic [SB_W-1:0]    chan_count;
		logic [STEP_W-1:0]  step_reg;
		logic [INV_W-1:0]   inv_reg;
		int unsigned        remain;
		longint             acc;
		logic [OUT_W-1:0]   expected[$];
		int                 errors;

		function new();
			bytes_sel  = SB_S16;
			chan_count = 1;
			step_reg   = ONE_Q;
			inv_reg    = INV_W'(ONE_Q);
			remain     = ONE_Q;
			acc        = 0;
			errors     = 0;
		endfunction

		function int unsigned eff_step();
			return (step_reg < ONE_Q) ? ONE_Q : step_reg;
		endfunction

		function longint round_away(longint v, int s);
			bit     neg;
			longint m;
			neg = v < 0;
			m = neg ? -v : v;
			m = (m + (longint'(1) << (s - 1))) >> s;
			return neg ? -m : m;
		endfunction

		function int level_of(logic [WORD_W-1:0] w);
			case (bytes_sel)
				SB_U8:   return int'(w[7:0]) - U8_OFFSET;
				SB_S16:  return int'(level_t'(w[15:8]));
				SB_S24:  return int'(level_t'(w[23:16]));
				SB_S32:  return int'(level_t'(w[31:24]));
				default: return 0;
			endcase
		endfunction

		function logic [OUT_W-1:0] window_sample();
			longint y;
			y = round_away(acc * longint'(inv_reg), 2 * FRAC_BITS);
			if (y > 127) y = 127;
			if (y < -128) y = -128;
			return OUT_W'(y);
		endfunction

		function void write_reg(cfg_idx_t idx, int unsigned val);
			case (idx)
				CFG_SAMPLE_BYTES: bytes_sel = SB_W'(val);
				CFG_NUM_CHANNELS: chan_count = SB_W'(val);
				CFG_STEP: begin
					step_reg = STEP_W'(val);
					remain   = eff_step();
					acc      = 0;
				end
				CFG_INV_STEP:     inv_reg = INV_W'(val);
				default: ;
			endcase
		endfunction

		function void note_frame(logic [IN_DATA_W-1:0] frame);
			int unsigned n;
			int unsigned stp;
			int          sum;
			longint      recip;
			longint      avg;
			longint      part;
			n = chan_count;
			if (n < 1) n = 1;
			if (n > MAX_CHANNELS) n = MAX_CHANNELS;
			sum = 0;
			for (int i = 0; i < n; i++)
				if (i < IN_WORDS) sum += level_of(frame[i*WORD_W +: WORD_W]);
			recip = (longint'(ONE_Q) + n / 2) / n;
			avg = longint'(sum) * recip;
			stp = eff_step();
			if (remain == 0) remain = stp;
			if (remain >= ONE_Q) begin
				acc += avg;
				remain -= ONE_Q;
				if (remain == 0) begin
					expected.push_back(window_sample());
					acc = 0;
					remain = stp;
				end
			end else begin
				part = round_away(avg * longint'(remain), FRAC_BITS);
				acc += part;
				expected.push_back(window_sample());
				acc = avg - part;
				remain = stp - ONE_Q + remain;
			end
		endfunction

		function void check_sample(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] exp_val;
			if (expected.size() == 0) begin
				$display("%0t: out_sample with none expected, actual %0d", $time, $signed(got));
				errors++;
			end else begin
				exp_val = expected.pop_front();
				if (exp_val !== got) begin
					$display("%0t: out_sample expected %0d, actual %0d", $time,
						$signed(exp_val), $signed(got));
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	decim_scoreboard sb = new();
	int s_gap_max;
	int r_gap_max;
	int hold_len;
	int idle_cycles;

	audio_box_filter_downsampler_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [IN_DATA_W-1:0] frame_of(logic [WORD_W-1:0] w0, w1, w2, w3);
		return {w3, w2, w1, w0};
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return 32'h8080_8080;
			3:       return 32'h7F7F_7F7F;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_frame(logic [IN_DATA_W-1:0] frame);
		int gap;
		gap = $urandom_range(0, s_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= frame;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic end_phase();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_setting(int unsigned bytes, chans, stp, inv, bit wr_step);
		write_reg(CFG_SAMPLE_BYTES, bytes);
		write_reg(CFG_NUM_CHANNELS, chans);
		if (wr_step) write_reg(CFG_STEP, stp);
		write_reg(CFG_INV_STEP, inv);
		cfg_we <= 1'b0;
	endtask

	// receiver: random stall per transaction, one long hold on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, r_gap_max);
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_frame(s_tdata);
			if (m_tvalid && m_tready) sb.check_sample(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles++;
			end
		end
	end

	initial begin
		int unsigned bytes;
		int unsigned chans;
		int unsigned stp;
		int unsigned eff;
		int unsigned inv;
		bit          wr_step;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		m_tready    <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= CFG_SAMPLE_BYTES;
		cfg_data    <= '0;
		arst_n      <= 1'b0;
		s_gap_max   = 18;
		r_gap_max   = 18;
		hold_len    = 0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(frame_of('0, '0, '0, '0));
		send_frame(frame_of('1, '1, '1, '1));
		send_frame(frame_of(32'h0000_8000, '0, '0, '0));
		send_frame(frame_of(32'h0000_7F00, '1, '1, '1));
		end_phase();

		apply_setting(SB_U8, 4, ONE_Q, ONE_Q, 1'b1);
		send_frame(frame_of('0, '0, '0, '0));
		send_frame(frame_of('1, '1, '1, '1));
		send_frame(frame_of(32'h8080_8080, 32'h8080_8080, 32'h8080_8080, 32'h8080_8080));
		end_phase();

		apply_setting(SB_S24, 3, 32'h1_8000, 43691, 1'b1);
		send_frame(frame_of(32'h00FF_0000, 32'h0080_0000, 32'h007F_0000, '1));
		send_frame(frame_of(32'h007F_0000, 32'h007F_0000, 32'h007F_0000, '0));
		send_frame(frame_of(32'h0080_0000, 32'h0080_0000, 32'h00FF_0000, '1));
		send_frame(frame_of($urandom, $urandom, $urandom, $urandom));
		end_phase();

		apply_setting(0, 0, 32'h8000, 0, 1'b1);
		send_frame(frame_of('1, 32'h8080_8080, '0, '1));
		send_frame(frame_of($urandom, $urandom, $urandom, $urandom));
		end_phase();

		apply_setting(SB_S32, 7, 32'h2_0000, 32'h1_FFFF, 1'b1);
		send_frame(frame_of(32'h7F00_0000, 32'h7F00_0000, 32'h7F00_0000, 32'h7F00_0000));
		send_frame(frame_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_frame(frame_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_frame(frame_of(32'h80FF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		end_phase();

		apply_setting(SB_U8, 2, 32'hFF_FFFF, 1, 1'b1);
		send_frame(frame_of($urandom, $urandom, $urandom, $urandom));
		send_frame(frame_of('1, '1, '0, '0));
		end_phase();

		for (int p = 0; p < 8; p++) begin
			if (p == 2) begin
				bytes   = SB_S16;
				chans   = 1;
				stp     = ONE_Q;
				inv     = ONE_Q;
				wr_step = 1'b1;
			end else begin
				bytes = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
				chans = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
				case ($urandom_range(0, 7))
					0:       stp = $urandom_range(0, ONE_Q - 1);
					1:       stp = $urandom_range(1, 4) * ONE_Q;
					default: stp = $urandom_range(ONE_Q, 4 * ONE_Q);
				endcase
				eff = (stp < ONE_Q) ? ONE_Q : stp;
				inv = 32'(((64'd1 << (2 * FRAC_BITS)) + eff / 2) / eff);
				if ($urandom_range(0, 4) == 0) inv = $urandom_range(0, 2 ** INV_W - 1);
				wr_step = $urandom_range(0, 3) != 0;
			end
			apply_setting(bytes, chans, stp, inv, wr_step);
			if (p == 2) begin
				s_gap_max = 0;
				r_gap_max = 0;
				hold_len  = PRESSURE_HOLD;
			end else begin
				s_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
				r_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
			end
			for (int i = 0; i < 50; i++)
				send_frame(frame_of(pick_word(), pick_word(), pick_word(), pick_word()));
			end_phase();
		end

		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/abfd_pkg.sv
sv/abfd_lane.sv
sv/abfd_merge.sv
sv/abfd_emit.sv
sv/audio_box_filter_downsampler_core.sv
verif/audio_box_filter_downsampler_core_tb.sv
